[hdl/tbfw_pkg.sv]
// shared types and constants for the tape bi-phase frame writer
`default_nettype none
package tbfw_pkg;

    localparam int unsigned LOOKAHEAD_DEPTH_DEF = 8;
    localparam logic [7:0] SPEED_RESET  = 8'd20;
    localparam logic [7:0] SYNC_BYTE    = 8'hE6;
    localparam logic [7:0] HIGH_LEVEL   = 8'hEF;
    localparam logic [7:0] LOW_LEVEL    = 8'h10;
    localparam logic [7:0] PATTERN_BYTE = 8'h55;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PREAMBLE,
        PH_SYNC,
        PH_FETCH,
        PH_DATA
    } t_phase;

    typedef enum logic {
        OP_PUSH,
        OP_TICK
    } t_op_kind;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0] sample;
        logic       sample_valid;
        logic       byte_ready;
        logic       push_rejected;
        logic       file_done;
    } t_out_word;

    // classified word as it sits in the queue between front and back
    typedef struct packed {
        t_op_kind   kind;
        logic [7:0] data;
        logic       last;
    } t_op;

endpackage
`default_nettype wire

[hdl/tape_biphase_frame_writer_unit.sv]
// top level of the tape bi-phase frame writer: front queue and back end
// a word passes through the front queue, then the back end registers its result at the output
// throughput: one word per cycle, pushes and ticks alike, while the output is not stalled;
// the back end updates the lookahead store and encoder counters for every word it takes
// reset: synchronous active low; clears control state, speed returns to 20
// the lookahead store holds no reset value and needs no clearing pass
`default_nettype none
module tape_biphase_frame_writer_unit #(
    parameter int unsigned LOOKAHEAD_DEPTH = tbfw_pkg::LOOKAHEAD_DEPTH_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire  [7:0]          i_cfg_wdata,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  tbfw_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output tbfw_pkg::t_out_word o_out_data
);

    logic          q_valid;
    tbfw_pkg::t_op q_op;
    logic          q_pop;

    tbfw_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_q_valid  (q_valid),
        .o_q_op     (q_op),
        .i_q_pop    (q_pop)
    );

    tbfw_back #(
        .LOOKAHEAD_DEPTH (LOOKAHEAD_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (q_valid),
        .i_q_op      (q_op),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

[hdl/tbfw_front.sv]
// front end: accepts input words, decodes the command and queues them
`default_nettype none
module tbfw_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  tbfw_pkg::t_in_word  i_in_data,
    output logic                o_q_valid,
    output tbfw_pkg::t_op       o_q_op,
    input  wire                 i_q_pop
);

    tbfw_pkg::t_op r_slot [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;

    tbfw_pkg::t_op n_op;
    logic          wr_en;
    logic          rd_en;

    always_comb begin
        n_op.kind = (i_in_data.command == tbfw_pkg::CMD_TICK) ?
                    tbfw_pkg::OP_TICK : tbfw_pkg::OP_PUSH;
        n_op.data = i_in_data.data_byte;
        n_op.last = i_in_data.last_byte;
    end

    assign o_in_stall = (r_count == 2'd2);
    assign wr_en      = i_in_valid && !o_in_stall;
    assign rd_en      = i_q_pop && (r_count != 2'd0);
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_op     = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (rd_en) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot[r_wr_ptr] <= n_op;
        end
    end

    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("queue count out of range");

    a_q_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd1) |-> (r_wr_ptr != r_rd_ptr))
        else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

[hdl/tbfw_back.sv]
// back end: lookahead store, framing sequencer, bi-phase encoder, output register
`default_nettype none
module tbfw_back #(
    parameter int unsigned LOOKAHEAD_DEPTH = tbfw_pkg::LOOKAHEAD_DEPTH_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire  [7:0]          i_cfg_wdata,
    input  wire                 i_q_valid,
    input  tbfw_pkg::t_op       i_q_op,
    output logic                o_q_pop,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output tbfw_pkg::t_out_word o_out_data
);

    localparam int unsigned CNT_W = $clog2(LOOKAHEAD_DEPTH + 1);
    localparam int unsigned IDX_W = $clog2(LOOKAHEAD_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LOOKAHEAD_DEPTH);

    logic [7:0]          r_store [LOOKAHEAD_DEPTH];
    logic [CNT_W-1:0]    r_count;
    logic                r_last_seen;
    tbfw_pkg::t_phase    r_phase;
    logic                r_pattern;
    logic [7:0]          r_sent;
    logic [7:0]          r_shift;
    logic [2:0]          r_bitpos;
    logic                r_half;
    logic [7:0]          r_repeat_left;
    logic [7:0]          r_speed;
    logic                r_out_valid;
    tbfw_pkg::t_out_word r_out;

    logic [CNT_W-1:0]    n_count;
    logic                n_last_seen;
    tbfw_pkg::t_phase    n_phase;
    logic                n_pattern;
    logic [7:0]          n_sent;
    logic [7:0]          n_shift;
    logic [2:0]          n_bitpos;
    logic                n_half;
    logic [7:0]          n_repeat_left;
    tbfw_pkg::t_out_word n_out;

    logic take;
    logic is_push;
    logic is_tick;
    logic rejected;
    logic do_push;
    logic do_pop;
    logic start_go;
    logic fs_pre;
    logic fs_post;
    logic keep;
    logic drop;
    logic fetch;
    logic pat_new;
    logic [7:0] spd;

    assign take     = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_q_pop  = take;
    assign is_push  = (i_q_op.kind == tbfw_pkg::OP_PUSH);
    assign is_tick  = (i_q_op.kind == tbfw_pkg::OP_TICK);
    assign rejected = r_last_seen || (r_count >= DEPTH_C);
    assign do_push  = take && is_push && !rejected;

    // start of file: decide whether a leading sync byte is dropped and which preamble
    assign start_go = (r_phase == tbfw_pkg::PH_IDLE) && (r_count != '0) &&
                      ((r_count >= CNT_W'(5)) || r_last_seen);
    assign fs_pre   = (r_count >= CNT_W'(4)) &&
                      (r_store[0] == tbfw_pkg::SYNC_BYTE) &&
                      (r_store[1] == tbfw_pkg::SYNC_BYTE) &&
                      (r_store[2] == tbfw_pkg::SYNC_BYTE) &&
                      (r_store[3] == tbfw_pkg::SYNC_BYTE);
    assign fs_post  = (r_count >= CNT_W'(5)) &&
                      (r_store[1] == tbfw_pkg::SYNC_BYTE) &&
                      (r_store[2] == tbfw_pkg::SYNC_BYTE) &&
                      (r_store[3] == tbfw_pkg::SYNC_BYTE) &&
                      (r_store[4] == tbfw_pkg::SYNC_BYTE);
    assign keep     = (r_count >= CNT_W'(5)) && fs_pre &&
                      (r_store[4] != tbfw_pkg::SYNC_BYTE);
    assign drop     = start_go && (r_store[0] == tbfw_pkg::SYNC_BYTE) && !keep;
    assign pat_new  = drop ? fs_post : fs_pre;
    assign fetch    = (r_phase == tbfw_pkg::PH_FETCH) && (r_count != '0);
    assign do_pop   = take && is_tick && (drop || fetch);
    assign spd      = (r_speed == 8'd0) ? 8'd1 : r_speed;

    always_comb begin
        logic [7:0]       rl_load;
        logic [2:0]       bp_next;
        logic [7:0]       sent_next;
        tbfw_pkg::t_phase ph_e;

        n_count       = r_count;
        n_last_seen   = r_last_seen;
        n_phase       = r_phase;
        n_pattern     = r_pattern;
        n_sent        = r_sent;
        n_shift       = r_shift;
        n_bitpos      = r_bitpos;
        n_half        = r_half;
        n_repeat_left = r_repeat_left;
        n_out         = '0;
        rl_load       = 8'd0;
        bp_next       = 3'd0;
        sent_next     = 8'd0;
        ph_e          = r_phase;

        if (is_push) begin
            if (rejected) begin
                n_out.push_rejected = 1'b1;
            end else begin
                n_count = r_count + CNT_W'(1);
                if (i_q_op.last) begin
                    n_last_seen = 1'b1;
                end
            end
        end else begin
            if (start_go) begin
                ph_e          = tbfw_pkg::PH_PREAMBLE;
                n_sent        = 8'd0;
                n_pattern     = pat_new;
                n_shift       = pat_new ? tbfw_pkg::PATTERN_BYTE : 8'd0;
                n_bitpos      = 3'd0;
                n_half        = 1'b0;
                n_repeat_left = 8'd0;
                if (drop) begin
                    n_count = r_count - CNT_W'(1);
                end
            end else if (fetch) begin
                ph_e          = tbfw_pkg::PH_DATA;
                n_shift       = r_store[0];
                n_bitpos      = 3'd0;
                n_half        = 1'b0;
                n_repeat_left = 8'd0;
                n_count       = r_count - CNT_W'(1);
            end
            n_phase = ph_e;

            if (ph_e inside {tbfw_pkg::PH_PREAMBLE, tbfw_pkg::PH_SYNC,
                             tbfw_pkg::PH_DATA}) begin
                n_out.sample_valid = 1'b1;
                n_out.sample = (n_shift[7] != n_half) ?
                               tbfw_pkg::HIGH_LEVEL : tbfw_pkg::LOW_LEVEL;
                rl_load = (n_repeat_left == 8'd0) ? spd : n_repeat_left;
                n_repeat_left = rl_load - 8'd1;
                if (n_repeat_left == 8'd0) begin
                    if (!n_half) begin
                        n_half = 1'b1;
                    end else begin
                        n_half   = 1'b0;
                        n_shift  = {n_shift[6:0], 1'b0};
                        bp_next  = n_bitpos + 3'd1;
                        n_bitpos = bp_next;
                        if (bp_next == 3'd0) begin
                            if (ph_e == tbfw_pkg::PH_PREAMBLE) begin
                                sent_next = n_sent + 8'd1;
                                n_sent    = sent_next;
                                if (sent_next == 8'd0) begin
                                    n_phase = tbfw_pkg::PH_SYNC;
                                    n_shift = tbfw_pkg::SYNC_BYTE;
                                end else begin
                                    // pattern alternates every 64 bytes
                                    n_shift = (n_pattern && !sent_next[6]) ?
                                              tbfw_pkg::PATTERN_BYTE : 8'd0;
                                end
                            end else if ((n_count == '0) && r_last_seen) begin
                                n_out.file_done = 1'b1;
                                n_count     = '0;
                                n_last_seen = 1'b0;
                                n_phase     = tbfw_pkg::PH_IDLE;
                                n_pattern   = 1'b0;
                                n_sent      = 8'd0;
                                n_shift     = 8'd0;
                                n_bitpos    = 3'd0;
                            end else begin
                                n_phase = tbfw_pkg::PH_FETCH;
                            end
                        end
                    end
                end
            end
        end

        n_out.byte_ready = !n_last_seen && (n_count < DEPTH_C);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_last_seen   <= 1'b0;
            r_phase       <= tbfw_pkg::PH_IDLE;
            r_pattern     <= 1'b0;
            r_sent        <= 8'd0;
            r_shift       <= 8'd0;
            r_bitpos      <= 3'd0;
            r_half        <= 1'b0;
            r_repeat_left <= 8'd0;
            r_speed       <= tbfw_pkg::SPEED_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_speed <= i_cfg_wdata;
            end
            if (take) begin
                r_count       <= n_count;
                r_last_seen   <= n_last_seen;
                r_phase       <= n_phase;
                r_pattern     <= n_pattern;
                r_sent        <= n_sent;
                r_shift       <= n_shift;
                r_bitpos      <= n_bitpos;
                r_half        <= n_half;
                r_repeat_left <= n_repeat_left;
                r_out_valid   <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // lookahead store: written at the fill level, shifted down on a pop
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_store[r_count[IDX_W-1:0]] <= i_q_op.data;
        end else if (do_pop) begin
            for (int k = 0; k < LOOKAHEAD_DEPTH - 1; k++) begin
                r_store[k] <= r_store[k+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("lookahead count exceeds depth");

    a_sample_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.sample_valid) |->
        ((r_out.sample == tbfw_pkg::HIGH_LEVEL) || (r_out.sample == tbfw_pkg::LOW_LEVEL)))
        else $error("sample is not a line level");

    a_done_with_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.file_done) |-> (r_out.sample_valid && !r_out.push_rejected))
        else $error("file done without a sample");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == tbfw_pkg::PH_IDLE) |-> ((r_repeat_left == 8'd0) && !r_half))
        else $error("encoder state left over while idle");

endmodule
`default_nettype wire

[tb/tb_tape_biphase_frame_writer_unit.sv]
// self-checking testbench for the tape bi-phase frame writer: predicts every output word
module tb_tape_biphase_frame_writer_unit;

    localparam int DEPTH       = tbfw_pkg::LOOKAHEAD_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 5_000_000;

    typedef logic [7:0] t_byte_q[$];

    // tracks the writer's frame state and the output words still due
    class biphase_sample_tracker;
        logic [7:0]          speed;
        logic [7:0]          lookahead[$];
        logic                last_seen;
        tbfw_pkg::t_phase    phase;
        logic                pattern_pre;
        logic [7:0]          pre_sent;
        logic [7:0]          shift;
        logic [2:0]          bit_pos;
        logic                second_half;
        logic [7:0]          repeat_left;
        tbfw_pkg::t_out_word due_words[$];
        logic                last_rejected;
        int                  mismatches;
        int                  checked;
        int                  rejects;
        int                  starved;
        int                  samples;
        int                  files_done;

        function new();
            speed = tbfw_pkg::SPEED_RESET;
            mismatches = 0;
            checked = 0;
            rejects = 0;
            starved = 0;
            samples = 0;
            files_done = 0;
            clear_file();
        endfunction

        function void load_byte(logic [7:0] b);
            shift = b;
            bit_pos = 3'd0;
            second_half = 1'b0;
            repeat_left = 8'd0;
        endfunction

        function void clear_file();
            lookahead.delete();
            last_seen = 1'b0;
            phase = tbfw_pkg::PH_IDLE;
            pattern_pre = 1'b0;
            pre_sent = 8'd0;
            load_byte(8'h00);
        endfunction

        function logic leads_with_syncs();
            if (lookahead.size() < 4) return 1'b0;
            for (int k = 0; k < 4; k++) begin
                if (lookahead[k] != tbfw_pkg::SYNC_BYTE) return 1'b0;
            end
            return 1'b1;
        endfunction

        // a pattern preamble alternates 64 pattern bytes and 64 zeros; any other is all zeros
        function logic [7:0] preamble_fill(logic [7:0] idx);
            if (!pattern_pre) return 8'h00;
            return (idx[6] == 1'b0) ? tbfw_pkg::PATTERN_BYTE : 8'h00;
        endfunction

        function logic emit_sample(output logic [7:0] level);
            level = (shift[7] != second_half) ? tbfw_pkg::HIGH_LEVEL : tbfw_pkg::LOW_LEVEL;
            if (repeat_left == 8'd0) repeat_left = (speed == 8'd0) ? 8'd1 : speed;
            repeat_left = repeat_left - 8'd1;
            if (repeat_left != 8'd0) return 1'b0;
            if (!second_half) begin
                second_half = 1'b1;
                return 1'b0;
            end
            second_half = 1'b0;
            shift = shift << 1;
            bit_pos = bit_pos + 3'd1;
            if (bit_pos != 3'd0) return 1'b0;
            if (phase == tbfw_pkg::PH_PREAMBLE) begin
                pre_sent = pre_sent + 8'd1;
                if (pre_sent == 8'd0) begin
                    phase = tbfw_pkg::PH_SYNC;
                    load_byte(tbfw_pkg::SYNC_BYTE);
                end else begin
                    load_byte(preamble_fill(pre_sent));
                end
                return 1'b0;
            end
            if (lookahead.size() == 0 && last_seen) begin
                clear_file();
                files_done++;
                return 1'b1;
            end
            phase = tbfw_pkg::PH_FETCH;
            return 1'b0;
        endfunction

        function tbfw_pkg::t_out_word encode_step(tbfw_pkg::t_in_word w);
            tbfw_pkg::t_out_word r;
            logic                keep;
            logic [7:0]          level;
            r = '0;
            if (w.command == tbfw_pkg::CMD_PUSH) begin
                if (last_seen || lookahead.size() >= DEPTH) begin
                    r.push_rejected = 1'b1;
                    rejects++;
                end else begin
                    lookahead.push_back(w.data_byte);
                    if (w.last_byte) last_seen = 1'b1;
                end
            end else begin
                if (phase == tbfw_pkg::PH_IDLE && lookahead.size() > 0 &&
                    (lookahead.size() >= 5 || last_seen)) begin
                    // a leading sync survives only as exactly four syncs and a non-sync
                    keep = lookahead.size() >= 5 && leads_with_syncs() &&
                           lookahead[4] != tbfw_pkg::SYNC_BYTE;
                    if (lookahead[0] == tbfw_pkg::SYNC_BYTE && !keep)
                        void'(lookahead.pop_front());
                    pattern_pre = leads_with_syncs();
                    pre_sent = 8'd0;
                    phase = tbfw_pkg::PH_PREAMBLE;
                    load_byte(preamble_fill(8'd0));
                end
                if (phase == tbfw_pkg::PH_FETCH) begin
                    if (lookahead.size() > 0) begin
                        load_byte(lookahead.pop_front());
                        phase = tbfw_pkg::PH_DATA;
                    end else begin
                        starved++;
                    end
                end
                if (phase inside {tbfw_pkg::PH_PREAMBLE, tbfw_pkg::PH_SYNC,
                                  tbfw_pkg::PH_DATA}) begin
                    r.sample_valid = 1'b1;
                    r.file_done = emit_sample(level);
                    r.sample = level;
                    samples++;
                end
            end
            r.byte_ready = !last_seen && lookahead.size() < DEPTH;
            return r;
        endfunction

        function void note_word(tbfw_pkg::t_in_word w);
            tbfw_pkg::t_out_word r;
            r = encode_step(w);
            last_rejected = r.push_rejected;
            due_words.push_back(r);
        endfunction

        task report(string line);
            $display("mismatch %0d at result %0d: %s", mismatches + 1, checked, line);
            mismatches++;
        endtask

        task check_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report($sformatf("%s got %h want %h", name, got, want));
        endtask

        task check_word(tbfw_pkg::t_out_word got);
            tbfw_pkg::t_out_word want;
            if (due_words.size() == 0) begin
                report($sformatf("word %h arrived with nothing due", got));
            end else begin
                want = due_words.pop_front();
                check_field("sample", got.sample, want.sample);
                check_field("sample_valid", 8'(got.sample_valid), 8'(want.sample_valid));
                check_field("byte_ready", 8'(got.byte_ready), 8'(want.byte_ready));
                check_field("push_rejected", 8'(got.push_rejected), 8'(want.push_rejected));
                check_field("file_done", 8'(got.file_done), 8'(want.file_done));
            end
            checked++;
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [7:0]          i_cfg_wdata;
    logic                i_in_valid;
    logic                o_in_stall;
    tbfw_pkg::t_in_word  i_in_data;
    logic                o_out_valid;
    logic                i_out_stall;
    tbfw_pkg::t_out_word o_out_data;

    biphase_sample_tracker sb;
    int sent_words;
    int recv_words;
    int send_mode;
    int recv_mode;
    int cycle_count;

    tape_biphase_frame_writer_unit #(
        .LOOKAHEAD_DEPTH(DEPTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // idle modes: none, occasional gaps, a random gap (possibly none) drawn for every word
    function automatic int draw_mode();
        int r;
        r = $urandom_range(7);
        if (r < 3) return 0;
        if (r < 7) return 1;
        return 2;
    endfunction

    function automatic int draw_gap(int mode);
        if (mode == 0) return 0;
        if (mode == 1 && $urandom_range(7) != 0) return 0;
        return $urandom_range(14);
    endfunction

    function automatic t_byte_q make_file();
        t_byte_q q;
        int      shape;
        int      tail;
        shape = $urandom_range(6);
        tail = $urandom_range(7);
        case (shape)
            0: begin
                q.push_back($urandom_range(1) ? tbfw_pkg::SYNC_BYTE : 8'($urandom));
                tail = 0;
            end
            1, 2, 3: begin
                repeat (4) q.push_back(tbfw_pkg::SYNC_BYTE);
                if (shape == 1)
                    q.push_back(tbfw_pkg::SYNC_BYTE ^ 8'($urandom_range(1, 255)));
                if (shape == 2) repeat ($urandom_range(1, 2)) q.push_back(tbfw_pkg::SYNC_BYTE);
                if (shape == 3) tail = 0;
            end
            4: begin
                repeat ($urandom_range(1, 3)) q.push_back(tbfw_pkg::SYNC_BYTE);
                q.push_back(tbfw_pkg::SYNC_BYTE ^ 8'($urandom_range(1, 255)));
            end
            5: q.push_back(tbfw_pkg::SYNC_BYTE);
            default: tail = $urandom_range(1, 12);
        endcase
        repeat (tail)
            q.push_back(($urandom_range(5) == 0) ? tbfw_pkg::SYNC_BYTE : 8'($urandom));
        return q;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input logic cmd, input logic [7:0] data, input logic last);
        tbfw_pkg::t_in_word w;
        int                 gap;
        w.command = cmd;
        w.data_byte = data;
        w.last_byte = last;
        if (sent_words % 256 == 0) send_mode = draw_mode();
        gap = draw_gap(send_mode);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= w;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_word(w);
        sent_words++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.due_words.size() > 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_speed(input logic [7:0] value);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        sb.speed = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // pushes the file's bytes among ticks and keeps ticking until its last sample
    task automatic play_file(input t_byte_q bytes_q, input int push_odds, input int swap_at,
                             input logic [7:0] swap_speed);
        int start_files;
        int ticks;
        start_files = sb.files_done;
        ticks = 0;
        while (sb.files_done == start_files) begin
            if (bytes_q.size() > 0 && $urandom_range(push_odds - 1) == 0) begin
                send_word(tbfw_pkg::CMD_PUSH, bytes_q[0], bytes_q.size() == 1);
                // a full store turns the byte away, so it goes again later
                if (!sb.last_rejected) void'(bytes_q.pop_front());
            end else if ($urandom_range(47) == 0 &&
                         (sb.last_seen || sb.lookahead.size() >= DEPTH)) begin
                send_word(tbfw_pkg::CMD_PUSH, 8'($urandom), 1'($urandom));
            end else begin
                send_word(tbfw_pkg::CMD_TICK, 8'($urandom), 1'($urandom));
                ticks++;
                if (ticks == swap_at) write_speed(swap_speed);
            end
        end
    endtask

    initial begin
        t_byte_q rest;
        int      odds;
        sb = new();
        sent_words = 0;
        send_mode = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 8'd0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // idle tick, start held back until five bytes, full store, pattern preamble
        send_word(tbfw_pkg::CMD_TICK, 8'h00, 1'b0);
        repeat (4) send_word(tbfw_pkg::CMD_PUSH, tbfw_pkg::SYNC_BYTE, 1'b0);
        send_word(tbfw_pkg::CMD_TICK, 8'hFF, 1'b1);
        send_word(tbfw_pkg::CMD_PUSH, 8'h00, 1'b0);
        send_word(tbfw_pkg::CMD_PUSH, 8'hFF, 1'b0);
        send_word(tbfw_pkg::CMD_PUSH, 8'h80, 1'b0);
        send_word(tbfw_pkg::CMD_PUSH, 8'h7F, 1'b0);
        send_word(tbfw_pkg::CMD_PUSH, 8'h01, 1'b1);
        send_word(tbfw_pkg::CMD_TICK, 8'h00, 1'b0);
        send_word(tbfw_pkg::CMD_TICK, 8'hFF, 1'b1);
        rest = '{8'hAA, 8'h01};
        play_file(rest, 8, 70, 8'd1);

        for (int f = 0; f < 7; f++) begin
            case (f)
                0: write_speed(8'd255);
                1: write_speed(8'd0);
                2: write_speed(8'd2);
                3: write_speed(8'd1);
                default: ;
            endcase
            case ($urandom_range(2))
                0: odds = 2;
                1: odds = 8;
                default: odds = 200;
            endcase
            play_file(make_file(), odds, (f == 0) ? 1500 : -1, 8'd1);
        end

        wait_drained();
        $display("%0d words sent, %0d checked: %0d samples, %0d files closed, %0d pushes refused",
                 sent_words, sb.checked, sb.samples, sb.files_done, sb.rejects);
        $display("%0d ticks found the next data byte missing; speeds 20, 255, 0, 2 and 1 used",
                 sb.starved);
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        int gap;
        recv_words = 0;
        recv_mode = 0;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (recv_words % 256 == 0) recv_mode = draw_mode();
            gap = draw_gap(recv_mode);
            // long hold so the front queue fills and the input stalls
            if (recv_words == 400 || recv_words == 15000) gap = 300;
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            sb.check_word(o_out_data);
            recv_words++;
            @(negedge i_clk);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("run stopped at %0d cycles with %0d words still due",
                 cycle_count, sb.due_words.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

[files.f]
hdl/tbfw_pkg.sv
hdl/tbfw_front.sv
hdl/tbfw_back.sv
hdl/tape_biphase_frame_writer_unit.sv
tb/tb_tape_biphase_frame_writer_unit.sv
